>>> hdl/ffha_pkg.sv
// Shared types, constants and codes for the first-fit heap allocator.
// No dependencies; used by first_fit_heap_allocator_unit.
`default_nettype none
package ffha_pkg;

   localparam int HEAP_BYTES   = 65536;
   localparam int MAX_BLOCKS   = 64;
   localparam int HEADER_BYTES = 48;
   localparam int IDX_W        = $clog2(MAX_BLOCKS);
   localparam int CNT_W        = 7;
   localparam int ROUND_MASK   = 15;
   localparam int MIN_SPLIT    = 16;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_NOFIT  = 3'd1;
   localparam logic [2:0] ST_ZERO   = 3'd2;
   localparam logic [2:0] ST_NOTBLK = 3'd3;
   localparam logic [2:0] ST_FREED  = 3'd4;

   typedef struct packed {
      logic        cmd;
      logic [15:0] request_size;
      logic [15:0] release_offset;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [15:0]      payload_offset;
      logic [16:0]      bytes_in_use;
      logic [16:0]      bytes_free;
      logic [CNT_W-1:0] blocks_total;
      logic [CNT_W-1:0] blocks_in_use;
   } rsp_type;

   typedef struct packed {
      logic [15:0] start;
      logic [15:0] length;
      logic        busy;
   } entry_type;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_SCAN_RD, S_SCAN_EV, S_UP_RD, S_UP_WR, S_SPLIT_WR,
      S_GRANT_WR, S_NX_RD, S_NX_EV, S_PV_RD, S_PV_EV, S_MRG_WR, S_DN_RD,
      S_DN_WR, S_FIN
   } state_type;

endpackage
`default_nettype wire

>>> hdl/ffha_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

>>> hdl/first_fit_heap_allocator_unit.sv
// First-fit heap allocator: block table in one RAM, walked by a small sequencer.
// Depends on ffha_pkg and ffha_ram.
// Accept to rsp_valid: a zero-size allocate goes straight to the response; otherwise the
// unit reads and evaluates each table entry scanned, and reads and writes each entry moved
// on a split or merge; the response waits while a previous one is held by rsp_stall.
// Throughput: one word at a time; the single RAM read port sets the pace.
// Reset: synchronous; after reset the S_INIT state writes the initial free block.
`default_nettype none
module first_fit_heap_allocator_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ffha_pkg::req_type req_word,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ffha_pkg::rsp_type     rsp_word
);

   localparam int IW = ffha_pkg::IDX_W;
   localparam int CW = ffha_pkg::CNT_W;

   // sequencer state
   ffha_pkg::state_type state_ff, state_in;

   // latched request
   logic        cmd_ff, cmd_in;
   logic [16:0] need_ff, need_in;     // rounded size, may reach 65536
   logic [15:0] off_ff, off_in;

   // table walk
   logic [CW-1:0] idx_ff, idx_in;     // scan position, then hit position
   logic [CW-1:0] k_ff, k_in;         // move pointer
   logic [CW-1:0] lim_ff, lim_in;     // table size before a merge
   logic [1:0]    rm_ff, rm_in;       // entries removed by a merge
   ffha_pkg::entry_type cur_ff, cur_in;
   logic        split_ff, split_in;
   logic        mn_ff, mn_in;         // merge with next
   logic        mp_ff, mp_in;         // merge with previous
   logic [15:0] ml_ff, ml_in;         // merged length
   logic [15:0] ps_ff, ps_in;         // previous block start

   // result
   logic [2:0]  status_ff, status_in;
   logic [15:0] pay_ff, pay_in;

   // running totals
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] busy_ff, busy_in;
   logic [16:0]   used_ff, used_in;
   logic [16:0]   free_ff, free_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   ffha_pkg::rsp_type rsp_ff, rsp_in;

   // RAM port
   logic                we;
   logic [IW-1:0]       waddr, raddr;
   ffha_pkg::entry_type wdata, rdata;

   ffha_ram #(
      .WIDTH($bits(ffha_pkg::entry_type)),
      .DEPTH(ffha_pkg::MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_addr (raddr),
      .rd_data (rdata)
   );

   localparam logic [16:0] HDR17  = 17'(ffha_pkg::HEADER_BYTES);
   localparam logic [15:0] HDR16  = 16'(ffha_pkg::HEADER_BYTES);
   localparam logic [17:0] SPLIT18 =
      18'(ffha_pkg::HEADER_BYTES + ffha_pkg::MIN_SPLIT);
   localparam logic [CW-1:0] MAXB = CW'(ffha_pkg::MAX_BLOCKS);

   assign req_stall = (state_ff != ffha_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   logic        out_free;
   logic        hit_fit;
   logic        hit_off;
   logic [15:0] glen;
   logic [16:0] hdr_add;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      need_in      = need_ff;
      off_in       = off_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      lim_in       = lim_ff;
      rm_in        = rm_ff;
      cur_in       = cur_ff;
      split_in     = split_ff;
      mn_in        = mn_ff;
      mp_in        = mp_ff;
      ml_in        = ml_ff;
      ps_in        = ps_ff;
      status_in    = status_ff;
      pay_in       = pay_ff;
      count_in     = count_ff;
      busy_in      = busy_ff;
      used_in      = used_ff;
      free_in      = free_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      we           = 1'b0;
      waddr        = '0;
      wdata        = '0;
      raddr        = '0;

      out_free = !rsp_valid_ff || !rsp_stall;
      hit_fit  = !rdata.busy && ({1'b0, rdata.length} >= need_ff);
      hit_off  = ({1'b0, rdata.start} + HDR17) == {1'b0, off_ff};
      glen     = split_ff ? need_ff[15:0] : cur_ff.length;
      hdr_add  = (mn_ff ? HDR17 : 17'd0) + (mp_ff ? HDR17 : 17'd0);

      unique case (state_ff)
         ffha_pkg::S_INIT: begin
            // table starts as one free block spanning the heap
            we       = 1'b1;
            waddr    = '0;
            wdata    = '{start: 16'd0,
                         length: 16'(ffha_pkg::HEAP_BYTES - ffha_pkg::HEADER_BYTES),
                         busy: 1'b0};
            state_in = ffha_pkg::S_IDLE;
         end
         ffha_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_word.cmd;
               need_in   = ({1'b0, req_word.request_size} + 17'(ffha_pkg::ROUND_MASK))
                           & ~17'(ffha_pkg::ROUND_MASK);
               off_in    = req_word.release_offset;
               status_in = ffha_pkg::ST_OK;
               pay_in    = '0;
               idx_in    = '0;
               split_in  = 1'b0;
               mn_in     = 1'b0;
               mp_in     = 1'b0;
               if (req_word.cmd == ffha_pkg::CMD_ALLOC && req_word.request_size == 16'd0) begin
                  status_in = ffha_pkg::ST_ZERO;
                  state_in  = ffha_pkg::S_FIN;
               end else begin
                  state_in  = ffha_pkg::S_SCAN_RD;
               end
            end
         end
         ffha_pkg::S_SCAN_RD: begin
            raddr    = idx_ff[IW-1:0];
            state_in = ffha_pkg::S_SCAN_EV;
         end
         ffha_pkg::S_SCAN_EV: begin
            cur_in = rdata;
            if (cmd_ff == ffha_pkg::CMD_ALLOC) begin
               if (hit_fit) begin
                  if (({2'b0, rdata.length} >= ({1'b0, need_ff} + SPLIT18))
                      && (count_ff < MAXB)) begin
                     split_in = 1'b1;
                     k_in     = count_ff;
                     state_in = (count_ff == idx_ff + CW'(1)) ? ffha_pkg::S_SPLIT_WR
                                                               : ffha_pkg::S_UP_RD;
                  end else begin
                     state_in = ffha_pkg::S_GRANT_WR;
                  end
               end else if (idx_ff + CW'(1) >= count_ff) begin
                  status_in = ffha_pkg::ST_NOFIT;
                  state_in  = ffha_pkg::S_FIN;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = ffha_pkg::S_SCAN_RD;
               end
            end else begin
               if (hit_off) begin
                  if (rdata.busy) begin
                     ml_in = rdata.length;
                     if (idx_ff + CW'(1) < count_ff) begin
                        state_in = ffha_pkg::S_NX_RD;
                     end else if (idx_ff != '0) begin
                        state_in = ffha_pkg::S_PV_RD;
                     end else begin
                        state_in = ffha_pkg::S_MRG_WR;
                     end
                  end else begin
                     status_in = ffha_pkg::ST_FREED;
                     state_in  = ffha_pkg::S_FIN;
                  end
               end else if (idx_ff + CW'(1) >= count_ff) begin
                  status_in = ffha_pkg::ST_NOTBLK;
                  state_in  = ffha_pkg::S_FIN;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = ffha_pkg::S_SCAN_RD;
               end
            end
         end
         // open a slot after the hit: move entries up, top first
         ffha_pkg::S_UP_RD: begin
            raddr    = IW'(k_ff - CW'(1));
            state_in = ffha_pkg::S_UP_WR;
         end
         ffha_pkg::S_UP_WR: begin
            we       = 1'b1;
            waddr    = k_ff[IW-1:0];
            wdata    = rdata;
            k_in     = k_ff - CW'(1);
            state_in = (k_ff - CW'(1) == idx_ff + CW'(1)) ? ffha_pkg::S_SPLIT_WR
                                                          : ffha_pkg::S_UP_RD;
         end
         ffha_pkg::S_SPLIT_WR: begin
            we       = 1'b1;
            waddr    = IW'(idx_ff + CW'(1));
            wdata    = '{start: cur_ff.start + HDR16 + need_ff[15:0],
                         length: cur_ff.length - need_ff[15:0] - HDR16,
                         busy: 1'b0};
            state_in = ffha_pkg::S_GRANT_WR;
         end
         ffha_pkg::S_GRANT_WR: begin
            we       = 1'b1;
            waddr    = idx_ff[IW-1:0];
            wdata    = '{start: cur_ff.start, length: glen, busy: 1'b1};
            count_in = count_ff + (split_ff ? CW'(1) : CW'(0));
            used_in  = used_ff + 17'(glen);
            free_in  = free_ff - 17'(glen) - (split_ff ? HDR17 : 17'd0);
            busy_in  = busy_ff + CW'(1);
            pay_in   = cur_ff.start + HDR16;
            state_in = ffha_pkg::S_FIN;
         end
         ffha_pkg::S_NX_RD: begin
            raddr    = IW'(idx_ff + CW'(1));
            state_in = ffha_pkg::S_NX_EV;
         end
         ffha_pkg::S_NX_EV: begin
            if (!rdata.busy) begin
               mn_in = 1'b1;
               ml_in = ml_ff + HDR16 + rdata.length;
            end
            state_in = (idx_ff != '0) ? ffha_pkg::S_PV_RD : ffha_pkg::S_MRG_WR;
         end
         ffha_pkg::S_PV_RD: begin
            raddr    = IW'(idx_ff - CW'(1));
            state_in = ffha_pkg::S_PV_EV;
         end
         ffha_pkg::S_PV_EV: begin
            if (!rdata.busy) begin
               mp_in = 1'b1;
               ml_in = rdata.length + HDR16 + ml_ff;
               ps_in = rdata.start;
            end
            state_in = ffha_pkg::S_MRG_WR;
         end
         ffha_pkg::S_MRG_WR: begin
            we       = 1'b1;
            waddr    = mp_ff ? IW'(idx_ff - CW'(1)) : idx_ff[IW-1:0];
            wdata    = '{start: (mp_ff ? ps_ff : cur_ff.start), length: ml_ff, busy: 1'b0};
            rm_in    = {1'b0, mn_ff} + {1'b0, mp_ff};
            lim_in   = count_ff;
            k_in     = idx_ff + CW'(1) + (mn_ff ? CW'(1) : CW'(0));
            count_in = count_ff - CW'({1'b0, mn_ff} + {1'b0, mp_ff});
            used_in  = used_ff - 17'(cur_ff.length);
            free_in  = free_ff + 17'(cur_ff.length) + hdr_add;
            busy_in  = busy_ff - CW'(1);
            if ((mn_ff || mp_ff)
                && (idx_ff + CW'(1) + (mn_ff ? CW'(1) : CW'(0)) < count_ff)) begin
               state_in = ffha_pkg::S_DN_RD;
            end else begin
               state_in = ffha_pkg::S_FIN;
            end
         end
         // close the gap: move later entries down by the removed count
         ffha_pkg::S_DN_RD: begin
            raddr    = k_ff[IW-1:0];
            state_in = ffha_pkg::S_DN_WR;
         end
         ffha_pkg::S_DN_WR: begin
            we       = 1'b1;
            waddr    = IW'(k_ff - CW'(rm_ff));
            wdata    = rdata;
            k_in     = k_ff + CW'(1);
            state_in = (k_ff + CW'(1) < lim_ff) ? ffha_pkg::S_DN_RD : ffha_pkg::S_FIN;
         end
         ffha_pkg::S_FIN: begin
            if (out_free) begin
               rsp_in = '{status: status_ff,
                          payload_offset: (status_ff == ffha_pkg::ST_OK
                                           && cmd_ff == ffha_pkg::CMD_ALLOC) ? pay_ff : 16'd0,
                          bytes_in_use: used_ff,
                          bytes_free: free_ff,
                          blocks_total: count_ff,
                          blocks_in_use: busy_ff};
               rsp_valid_in = 1'b1;
               state_in     = ffha_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ffha_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffha_pkg::S_INIT;
         rsp_valid_ff <= 1'b0;
         count_ff     <= CW'(1);
         busy_ff      <= '0;
         used_ff      <= '0;
         free_ff      <= 17'(ffha_pkg::HEAP_BYTES - ffha_pkg::HEADER_BYTES);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         used_ff      <= used_in;
         free_ff      <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      need_ff   <= need_in;
      off_ff    <= off_in;
      idx_ff    <= idx_in;
      k_ff      <= k_in;
      lim_ff    <= lim_in;
      rm_ff     <= rm_in;
      cur_ff    <= cur_in;
      split_ff  <= split_in;
      mn_ff     <= mn_in;
      mp_ff     <= mp_in;
      ml_ff     <= ml_in;
      ps_ff     <= ps_in;
      status_ff <= status_in;
      pay_ff    <= pay_in;
      rsp_ff    <= rsp_in;
   end

`ifndef SYNTH
   // table never empty and never past capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CW'(1)) && (count_ff <= MAXB))
      else $error("block count out of range");

   a_busy_le_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff <= count_ff)
      else $error("more used blocks than blocks");

   // payloads plus headers always cover the heap exactly
   a_heap_balance: assert property (@(posedge clock) disable iff (reset)
      (19'(used_ff) + 19'(free_ff) + 19'(count_ff) * 19'(ffha_pkg::HEADER_BYTES))
      == 19'(ffha_pkg::HEAP_BYTES))
      else $error("heap byte totals do not balance");
`endif

endmodule
`default_nettype wire
